FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define FBWC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checks that a condition never holds outside reset.
`define FBWC_NEVER(label, clk, rst_n, cond, msg) \
    `FBWC_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

FILE: hdl/fbwc_pkg.sv
`default_nettype none

package fbwc_pkg;

    // Default values of the top level parameters.
    localparam int unsigned PAGES_PER_BANK_DEF = 128;
    localparam int unsigned PAGE_BYTES_DEF     = 2048;
    localparam int unsigned QUEUE_DEPTH_DEF    = 4;

    // Erase tracking map.
    localparam int unsigned MAP_ENTRIES = 256;
    localparam int unsigned MAP_IDX_W   = 8;

    // Flash window and protected range.
    localparam logic [31:0] FLASH_LOW   = 32'h0800_0000;
    localparam logic [31:0] FLASH_BANK2 = 32'h0804_0000;
    localparam logic [31:0] FLASH_END   = 32'h0808_0000;
    localparam logic [31:0] PROT_LOW    = 32'h0800_C000;
    localparam logic [31:0] PROT_END    = 32'h0801_0000;

    // Offset bits within one bank (the bank spans 256 KiB).
    localparam int unsigned BANK_OFF_W = 18;

    localparam logic [63:0] KEY_PAIR = 64'hCDEF_89AB_4567_0123;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    // Field widths.
    localparam int unsigned BASE_W      = 29;
    localparam int unsigned PAGE_W      = 7;
    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 112;

    typedef enum logic [1:0] {
        ACT_WRITE  = 2'd0,
        ACT_UNLOCK = 2'd1,
        ACT_LOCK   = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        KIND_PROGRAM = 3'd0,
        KIND_ERASE   = 3'd1,
        KIND_UNLOCK  = 3'd2,
        KIND_LOCK    = 3'd3,
        KIND_ACK     = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_NOT_FLASH    = 2'd1,
        ST_NOT_WRITABLE = 2'd2
    } status_t;

    // One classified request: the commands it causes, issued in the order
    // program, erase, unlock keys, lock, then always an acknowledge.
    typedef struct packed {
        logic                prog_en;
        logic                erase_en;
        logic                keys_en;
        logic                lock_en;
        logic [BASE_W-1:0]   prog_base;
        logic [63:0]         prog_data;
        logic                bank;
        logic [PAGE_W-1:0]   page;
        status_t             ack_status;
    } job_t;

    // One result word on the output side.
    typedef struct packed {
        kind_t             kind;
        logic [31:0]       op_address;
        logic [63:0]       program_data;
        logic              bank_select;
        logic [PAGE_W-1:0] page;
        status_t           status;
        logic              last;
    } result_t;

endpackage

`default_nettype wire

FILE: hdl/fbwc_queue.sv
`default_nettype none

module fbwc_queue #(
    parameter int unsigned DEPTH = fbwc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire fbwc_pkg::job_t push_job,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output fbwc_pkg::job_t     head_job
);
    import fbwc_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/fbwc_front.sv
`default_nettype none

module fbwc_front #(
    parameter int unsigned PAGES_PER_BANK = fbwc_pkg::PAGES_PER_BANK_DEF,
    parameter int unsigned PAGE_BYTES     = fbwc_pkg::PAGE_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  in_action,
    input  wire logic [31:0] in_address,
    input  wire logic [7:0]  in_data,
    input  wire logic        queue_full,
    output logic             push,
    output fbwc_pkg::job_t   job
);
    import fbwc_pkg::*;

    // PAGE_BYTES is a power of two, so the page is a slice of the offset.
    localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int unsigned IDX_SUM_W  = 10;

    logic                   unlocked_reg, unlocked_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [BASE_W-1:0]      pend_base_reg, pend_base_next;
    logic [63:0]            pend_word_reg, pend_word_next;
    logic [7:0]             mask_reg, mask_next;
    logic [MAP_ENTRIES-1:0] map_reg, map_next;

    logic                   accept;
    logic                   in_flash, in_prot;
    logic [BASE_W-1:0]      base;
    logic [2:0]             off;
    logic                   hit;
    logic [63:0]            word_start, merged;
    logic [7:0]             mask_start, mask_new;
    logic                   bank;
    logic [IDX_SUM_W-1:0]   page_ext, idx_sum;
    logic [MAP_IDX_W-1:0]   idx;

    assign in_ready = !queue_full;
    assign accept   = in_valid && !queue_full;

    // Address classification and page lookup.
    assign in_flash = (in_address >= FLASH_LOW) && (in_address < FLASH_END);
    assign in_prot  = (in_address >= PROT_LOW) && (in_address < PROT_END);
    assign base     = in_address[31:3];
    assign off      = in_address[2:0];
    assign bank     = (in_address >= FLASH_BANK2);
    assign page_ext = IDX_SUM_W'(in_address[BANK_OFF_W-1:PAGE_SHIFT]);
    assign idx_sum  = page_ext + (bank ? IDX_SUM_W'(PAGES_PER_BANK) : '0);
    assign idx      = idx_sum[MAP_IDX_W-1:0];
    assign hit      = pend_valid_reg && (base == pend_base_reg);

    // Byte merge into the pending doubleword.
    always_comb
    begin
        word_start = hit ? pend_word_reg : ALL_ONES;
        mask_start = hit ? mask_reg : 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            merged[8*i +: 8] = (off == 3'(i)) ? in_data : word_start[8*i +: 8];
        end
        mask_new = mask_start | (8'h01 << off);
    end

    // Request handling and state update.
    always_comb
    begin
        unlocked_next   = unlocked_reg;
        pend_valid_next = pend_valid_reg;
        pend_base_next  = pend_base_reg;
        pend_word_next  = pend_word_reg;
        mask_next       = mask_reg;
        map_next        = map_reg;
        push            = 1'b0;
        job             = '0;
        job.ack_status  = ST_OK;
        job.bank        = bank;
        job.page        = page_ext[PAGE_W-1:0];
        if (accept)
        begin
            unique case (in_action)
                ACT_WRITE:
                begin
                    push = 1'b1;
                    if (!in_flash)
                    begin
                        job.ack_status = ST_NOT_FLASH;
                    end
                    else if (in_prot)
                    begin
                        job.ack_status = ST_NOT_WRITABLE;
                    end
                    else
                    begin
                        // A new doubleword flushes the old one and erases its own page unless mapped as erased.
                        if (!hit)
                        begin
                            if (pend_valid_reg)
                            begin
                                job.prog_en   = 1'b1;
                                job.prog_base = pend_base_reg;
                                job.prog_data = pend_word_reg;
                            end
                            if (!map_reg[idx])
                            begin
                                job.erase_en  = 1'b1;
                                map_next[idx] = 1'b1;
                            end
                        end
                        // A full mask flushes at once.
                        if (mask_new == 8'hFF)
                        begin
                            job.prog_en     = 1'b1;
                            job.prog_base   = base;
                            job.prog_data   = merged;
                            pend_valid_next = 1'b0;
                            pend_base_next  = '0;
                            pend_word_next  = ALL_ONES;
                            mask_next       = 8'h00;
                        end
                        else
                        begin
                            pend_valid_next = 1'b1;
                            pend_base_next  = base;
                            pend_word_next  = merged;
                            mask_next       = mask_new;
                        end
                    end
                end
                ACT_UNLOCK:
                begin
                    push = 1'b1;
                    if (!unlocked_reg)
                    begin
                        job.keys_en   = 1'b1;
                        unlocked_next = 1'b1;
                    end
                end
                ACT_LOCK:
                begin
                    push = 1'b1;
                    if (unlocked_reg)
                    begin
                        if (pend_valid_reg)
                        begin
                            job.prog_en     = 1'b1;
                            job.prog_base   = pend_base_reg;
                            job.prog_data   = pend_word_reg;
                            pend_valid_next = 1'b0;
                            pend_base_next  = '0;
                            pend_word_next  = ALL_ONES;
                            mask_next       = 8'h00;
                        end
                        job.lock_en   = 1'b1;
                        unlocked_next = 1'b0;
                    end
                end
                default:
                begin
                    // The unused action code is dropped without a result.
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unlocked_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_base_reg  <= '0;
            pend_word_reg  <= ALL_ONES;
            mask_reg       <= 8'h00;
            map_reg        <= '0;
        end
        else
        begin
            unlocked_reg   <= unlocked_next;
            pend_valid_reg <= pend_valid_next;
            pend_base_reg  <= pend_base_next;
            pend_word_reg  <= pend_word_next;
            mask_reg       <= mask_next;
            map_reg        <= map_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/fbwc_back.sv
`default_nettype none

module fbwc_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          job_valid,
    input  wire fbwc_pkg::job_t job,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output fbwc_pkg::result_t  out_word
);
    import fbwc_pkg::*;

    // One bit per command of a job, lowest issued first.
    localparam logic [4:0] STEP_PROG  = 5'b00001;
    localparam logic [4:0] STEP_ERASE = 5'b00010;
    localparam logic [4:0] STEP_KEYS  = 5'b00100;
    localparam logic [4:0] STEP_LOCK  = 5'b01000;
    localparam logic [4:0] STEP_ACK   = 5'b10000;

    job_t       cur_job_reg, cur_job_next;
    logic [4:0] cur_mask_reg, cur_mask_next;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg, out_next;

    logic [4:0] sel, rem, job_mask;
    logic       advance;
    result_t    res;

    assign job_mask = {1'b1, job.lock_en, job.keys_en, job.erase_en, job.prog_en};
    assign sel      = cur_mask_reg & (~cur_mask_reg + 5'd1);
    assign rem      = cur_mask_reg & ~sel;
    assign advance  = (cur_mask_reg != '0) && (!out_valid_reg || out_ready);
    assign pop      = job_valid && ((cur_mask_reg == '0) || (advance && (rem == '0)));

    // Build the result for the selected command.
    always_comb
    begin
        res      = '0;
        res.kind = KIND_ACK;
        res.last = (rem == '0);
        unique case (sel)
            STEP_PROG:
            begin
                res.kind         = KIND_PROGRAM;
                res.op_address   = {cur_job_reg.prog_base, 3'b000};
                res.program_data = cur_job_reg.prog_data;
            end
            STEP_ERASE:
            begin
                res.kind        = KIND_ERASE;
                res.bank_select = cur_job_reg.bank;
                res.page        = cur_job_reg.page;
            end
            STEP_KEYS:
            begin
                res.kind         = KIND_UNLOCK;
                res.program_data = KEY_PAIR;
            end
            STEP_LOCK:
            begin
                res.kind = KIND_LOCK;
            end
            STEP_ACK:
            begin
                res.kind   = KIND_ACK;
                res.status = cur_job_reg.ack_status;
            end
            default:
            begin
                res.kind = KIND_ACK;
            end
        endcase
    end

    // Job sequencing and output register.
    always_comb
    begin
        cur_job_next   = cur_job_reg;
        cur_mask_next  = cur_mask_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (advance)
        begin
            cur_mask_next  = rem;
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (pop)
        begin
            cur_job_next  = job;
            cur_mask_next = job_mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_mask_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_mask_reg  <= cur_mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_job_reg <= cur_job_next;
        out_reg     <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

endmodule

`default_nettype wire

FILE: hdl/flash_byte_write_coalescer.sv
`default_nettype none

// Channel   Direction  tdata (low bit up)                        tuser    tlast
// s_axis    in         address[31:0], data_byte[39:32]           action   -
// m_axis    out        op_address, program_data, bank_select,    kind     last
//                      page, status, zero fill to 112 bits
//
// The front takes one request per cycle while the job queue has room; its
// state update (pending word, erase map, lock flag) settles in that cycle.
// The back issues one result word per cycle while the output is ready, so
// a request occupies the output for one to three result words, as it causes.
// The erase map is cleared at reset by its flip-flops; no clearing pass.
// Output stalls fill the queue first; the input stalls once it is full.
module flash_byte_write_coalescer #(
    parameter int unsigned PAGES_PER_BANK = fbwc_pkg::PAGES_PER_BANK_DEF,
    parameter int unsigned PAGE_BYTES     = fbwc_pkg::PAGE_BYTES_DEF,
    parameter int unsigned QUEUE_DEPTH    = fbwc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // address, data_byte
    input  wire logic [fbwc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // action
    input  wire logic [1:0]                       s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // op_address, program_data, bank_select, page, status
    output logic [fbwc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // kind
    output logic [2:0]                            m_axis_tuser,
    output logic                                  m_axis_tlast
);
    import fbwc_pkg::*;

    logic    queue_full;
    logic    push;
    job_t    push_job;
    logic    pop;
    logic    head_valid;
    job_t    head_job;
    result_t out_word;

    fbwc_front #(
        .PAGES_PER_BANK (PAGES_PER_BANK),
        .PAGE_BYTES     (PAGE_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_action  (s_axis_tuser),
        .in_address (s_axis_tdata[31:0]),
        .in_data    (s_axis_tdata[39:32]),
        .queue_full (queue_full),
        .push       (push),
        .job        (push_job)
    );

    fbwc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    fbwc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (head_valid),
        .job       (head_job),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (out_word)
    );

    // Pack the result word onto the output bus.
    assign m_axis_tdata = {6'b000000, out_word.status, out_word.page,
                           out_word.bank_select, out_word.program_data,
                           out_word.op_address};
    assign m_axis_tuser = out_word.kind;
    assign m_axis_tlast = out_word.last;

endmodule

`default_nettype wire

FILE: hdl/fbwc_checker.sv
`default_nettype none

`include "assert_macros.svh"

module fbwc_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             m_axis_tvalid,
    input wire logic                             m_axis_tready,
    input wire logic [fbwc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic [2:0]                       m_axis_tuser,
    input wire logic                             m_axis_tlast
);
    import fbwc_pkg::*;

    // A stalled word holds.
    `FBWC_ASSERT(a_out_hold, clk, rst_n,
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast),
        "stalled output word changed")

    // Every request ends with its acknowledge, and only there.
    `FBWC_ASSERT(a_last_is_ack, clk, rst_n,
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == KIND_ACK)),
        "tlast does not match the acknowledge word")

    // Only an acknowledge carries a status.
    `FBWC_NEVER(a_status_ack_only, clk, rst_n,
        m_axis_tvalid && (m_axis_tuser != KIND_ACK) && (m_axis_tdata[105:104] != 2'b00),
        "status set on a command word")

    // Program targets are aligned doublewords inside the flash window.
    `FBWC_ASSERT(a_prog_target, clk, rst_n,
        m_axis_tvalid && (m_axis_tuser == KIND_PROGRAM)
            |-> (m_axis_tdata[2:0] == 3'b000) && (m_axis_tdata[31:19] == 13'h0100),
        "program word outside the flash window")

    // Unlock words carry the fixed key pair.
    `FBWC_ASSERT(a_key_pair, clk, rst_n,
        m_axis_tvalid && (m_axis_tuser == KIND_UNLOCK) |-> (m_axis_tdata[95:32] == KEY_PAIR),
        "unlock word without the key pair")

endmodule

bind flash_byte_write_coalescer fbwc_checker u_fbwc_checker (.*);

`default_nettype wire

FILE: bench/tb_flash_byte_write_coalescer.sv
`timescale 1ns / 100ps

module tb_flash_byte_write_coalescer;

    import fbwc_pkg::*;

    // Action code 3 is not part of the package enum; the block ignores it.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam int CLK_HALF    = 6;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_WAIT  = 16;
    localparam int RANDOM_REQS = 500;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // address[31:0], data_byte[39:32]
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // action
    logic [1:0]             s_axis_tuser = 2'd0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // op_address[31:0], program_data[95:32], bank_select[96], page[103:97],
    // status[105:104], zero fill up to bit 111
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // kind
    logic [2:0]             m_axis_tuser;
    logic                   m_axis_tlast;

    // Predicted copy of the block state.
    logic                   unlocked;
    logic                   pend_valid;
    logic [BASE_W-1:0]      pend_base;
    logic [63:0]            pend_word;
    logic [7:0]             pend_mask;
    logic [MAP_ENTRIES-1:0] erased_pages;

    // Result words predicted for one request, then for all requests in flight.
    result_t                batch[$];
    result_t                expected_words[$];

    // Idling controls for the sender and the receiver.
    bit                     send_quiet = 1'b0;
    bit                     recv_quiet = 1'b0;
    int                     hold_requests = 0;
    int                     holds_done = 0;
    int                     stall_left = 0;

    int                     mismatches = 0;
    int                     requests_sent = 0;
    int                     words_checked = 0;
    int                     programs_expected = 0;
    int                     erases_expected = 0;

    flash_byte_write_coalescer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock generation.
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Reports one mismatch and counts it.
    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // Appends one predicted result word to the current request's batch.
    function automatic void add_result(kind_t k, logic [31:0] a, logic [63:0] d,
                                       logic b, logic [PAGE_W-1:0] p, status_t s);
        result_t r;
        r.kind         = k;
        r.op_address   = a;
        r.program_data = d;
        r.bank_select  = b;
        r.page         = p;
        r.status       = s;
        r.last         = 1'b0;
        batch.push_back(r);
    endfunction

    // Issues the pending doubleword as a program command and empties the buffer.
    function automatic void flush_pending();
        add_result(KIND_PROGRAM, {pend_base, 3'b000}, pend_word, 1'b0, '0, ST_OK);
        programs_expected++;
        pend_valid = 1'b0;
        pend_base  = '0;
        pend_word  = ALL_ONES;
        pend_mask  = '0;
    endfunction

    // Erases the page holding addr unless the map says it was erased already.
    function automatic void erase_if_new(logic [31:0] addr);
        logic        bank;
        logic [31:0] start;
        logic [31:0] pg;
        logic [7:0]  idx;
        bank  = (addr >= FLASH_BANK2);
        start = bank ? FLASH_BANK2 : FLASH_LOW;
        pg    = (addr - start) / PAGE_BYTES_DEF;
        idx   = pg[7:0] + (bank ? 8'(PAGES_PER_BANK_DEF) : 8'd0);
        if (!erased_pages[idx])
        begin
            add_result(KIND_ERASE, '0, '0, bank, pg[PAGE_W-1:0], ST_OK);
            erases_expected++;
            erased_pages[idx] = 1'b1;
        end
    endfunction

    // Predicts the result words of one accepted request and queues them.
    function automatic void predict_request(logic [1:0] act, logic [31:0] addr,
                                            logic [7:0] data);
        logic [BASE_W-1:0] base;
        logic [2:0]        off;
        batch.delete();
        if (act == ACT_WRITE)
        begin
            if (addr < FLASH_LOW || addr >= FLASH_END)
                add_result(KIND_ACK, '0, '0, 1'b0, '0, ST_NOT_FLASH);
            else if (addr >= PROT_LOW && addr < PROT_END)
                add_result(KIND_ACK, '0, '0, 1'b0, '0, ST_NOT_WRITABLE);
            else
            begin
                base = addr[31:3];
                off  = addr[2:0];
                // A new doubleword flushes the old one and may need an erase.
                if (!(pend_valid && base == pend_base))
                begin
                    if (pend_valid)
                        flush_pending();
                    erase_if_new({addr[31:3], 3'b000});
                end
                pend_valid          = 1'b1;
                pend_base           = base;
                pend_word[off*8 +: 8] = data;
                pend_mask[off]      = 1'b1;
                if (&pend_mask)
                    flush_pending();
                add_result(KIND_ACK, '0, '0, 1'b0, '0, ST_OK);
            end
        end
        else if (act == ACT_UNLOCK)
        begin
            if (!unlocked)
            begin
                add_result(KIND_UNLOCK, '0, KEY_PAIR, 1'b0, '0, ST_OK);
                unlocked = 1'b1;
            end
            add_result(KIND_ACK, '0, '0, 1'b0, '0, ST_OK);
        end
        else if (act == ACT_LOCK)
        begin
            if (unlocked)
            begin
                if (pend_valid)
                    flush_pending();
                add_result(KIND_LOCK, '0, '0, 1'b0, '0, ST_OK);
                unlocked = 1'b0;
            end
            add_result(KIND_ACK, '0, '0, 1'b0, '0, ST_OK);
        end
        if (batch.size() > 0)
        begin
            batch[batch.size() - 1].last = 1'b1;
            foreach (batch[i])
                expected_words.push_back(batch[i]);
        end
    endfunction

    // Mostly no gap, sometimes a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (send_quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 30);
    endfunction

    // Offers one request word, waits for the edge that accepts it, then for any gap.
    // The valid stays high afterwards unless a gap follows.
    task automatic send_request(input logic [1:0] act, input logic [31:0] addr,
                                input logic [7:0] data);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {data, addr};
        s_axis_tuser  <= act;
        predict_request(act, addr, data);
        if (act != ACT_UNUSED)
            requests_sent++;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Lowers the valid before any wait that is not part of the stream.
    task automatic idle_input();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    // Waits until every predicted word has come out.
    task automatic wait_drained();
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Compares one accepted output word with the oldest prediction.
    task automatic check_result();
        result_t got;
        result_t want;
        got.kind         = kind_t'(m_axis_tuser);
        got.op_address   = m_axis_tdata[31:0];
        got.program_data = m_axis_tdata[95:32];
        got.bank_select  = m_axis_tdata[96];
        got.page         = m_axis_tdata[103:97];
        got.status       = status_t'(m_axis_tdata[105:104]);
        got.last         = m_axis_tlast;
        words_checked++;
        if (|m_axis_tdata[OUT_TDATA_W-1:106])
            report_mismatch($sformatf("fill bits not zero: %h", m_axis_tdata[111:106]));
        if (expected_words.size() == 0)
        begin
            report_mismatch($sformatf("unexpected word kind %0d", m_axis_tuser));
            return;
        end
        want = expected_words.pop_front();
        if (got.kind != want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
        if (got.op_address != want.op_address)
            report_mismatch($sformatf("op_address %h, expected %h",
                                      got.op_address, want.op_address));
        if (got.program_data != want.program_data)
            report_mismatch($sformatf("program_data %h, expected %h",
                                      got.program_data, want.program_data));
        if (got.bank_select != want.bank_select)
            report_mismatch($sformatf("bank_select %0d, expected %0d",
                                      got.bank_select, want.bank_select));
        if (got.page != want.page)
            report_mismatch($sformatf("page %0d, expected %0d", got.page, want.page));
        if (got.status != want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      got.status, want.status));
        if (got.last != want.last)
            report_mismatch($sformatf("last %0d, expected %0d", got.last, want.last));
    endtask

    // Receiver: checks accepted words and stalls at random or on request.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (holds_done != hold_requests)
            begin
                holds_done    <= holds_done + 1;
                stall_left    <= LONG_HOLD - 1;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left    <= stall_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if (recv_quiet)
                m_axis_tready <= 1'b1;
            else
            begin
                case ($urandom_range(0, 99)) inside
                    [0:69]:  m_axis_tready <= 1'b1;
                    [70:94]:
                    begin
                        m_axis_tready <= 1'b0;
                        stall_left    <= $urandom_range(0, 2);
                    end
                    default:
                    begin
                        m_axis_tready <= 1'b0;
                        stall_left    <= $urandom_range(8, 40);
                    end
                endcase
            end
        end
    end

    // Edges of the flash window, the protected range and the banks, every
    // action, locking and unlocking twice, a full doubleword and the unused action.
    task automatic test_directed();
        send_request(ACT_WRITE, 32'h0000_0000, 8'h00);
        send_request(ACT_WRITE, 32'hFFFF_FFFF, 8'hFF);
        send_request(ACT_WRITE, 32'h07FF_FFFF, 8'h5A);
        send_request(ACT_WRITE, 32'h0808_0000, 8'hA5);
        send_request(ACT_WRITE, 32'h0800_C000, 8'h11);
        send_request(ACT_WRITE, 32'h0800_FFFF, 8'h22);
        // Writes while locked are buffered as usual.
        send_request(ACT_WRITE, 32'h0800_0000, 8'h00);
        send_request(ACT_WRITE, 32'h0800_0007, 8'hFF);
        send_request(ACT_WRITE, 32'h0800_BFFF, 8'hA5);
        send_request(ACT_WRITE, 32'h0801_0000, 8'h3C);
        send_request(ACT_WRITE, 32'h0803_FFFF, 8'hC3);
        send_request(ACT_WRITE, 32'h0804_0000, 8'h01);
        send_request(ACT_WRITE, 32'h0807_FFFF, 8'h80);
        send_request(ACT_UNLOCK, 32'h0, 8'h0);
        send_request(ACT_UNLOCK, 32'hFFFF_FFFF, 8'hFF);
        send_request(ACT_UNUSED, 32'h0800_0100, 8'h77);
        // Eight bytes of one doubleword flush on the last one.
        for (int i = 0; i < 8; i++)
            send_request(ACT_WRITE, 32'h0800_0100 + i, 8'(8'h10 * i + i));
        send_request(ACT_WRITE, 32'h0800_0008, 8'h99);
        send_request(ACT_LOCK, 32'h0, 8'h0);
        send_request(ACT_LOCK, 32'h0, 8'h0);
    endtask

    // Picks a writable in-flash doubleword, favoring a few pages and words.
    function automatic logic [31:0] pick_word_addr();
        logic [31:0] bank;
        logic [31:0] pg;
        logic [31:0] wd;
        bank = $urandom_range(0, 1);
        case ($urandom_range(0, 5))
            0:       pg = 0;
            1:       pg = 23;
            2:       pg = 32;
            3:       pg = 127;
            default: pg = $urandom_range(0, 127);
        endcase
        if (bank == 0 && pg >= 24 && pg <= 31)
            pg = pg + 8;
        wd = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
        return FLASH_LOW + (bank << BANK_OFF_W) + pg * PAGE_BYTES_DEF + wd * 8;
    endfunction

    // Random mix: mostly doubleword bursts, some lock traffic, some rejects.
    task automatic test_random();
        logic [31:0] base;
        logic [31:0] addr;
        int          nbytes;
        int          r;
        while (requests_sent < RANDOM_REQS)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                send_quiet = ($urandom_range(0, 3) == 0);
                recv_quiet = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                base = pick_word_addr();
                if ($urandom_range(0, 2) == 0)
                begin
                    for (int i = 0; i < 8; i++)
                        send_request(ACT_WRITE, base + i, 8'($urandom_range(0, 255)));
                end
                else
                begin
                    nbytes = $urandom_range(1, 8);
                    for (int i = 0; i < nbytes; i++)
                        send_request(ACT_WRITE, base + $urandom_range(0, 7),
                                     8'($urandom_range(0, 255)));
                end
            end
            else if (r < 80)
                send_request(ACT_UNLOCK, $urandom, 8'($urandom_range(0, 255)));
            else if (r < 90)
                send_request(ACT_LOCK, $urandom, 8'($urandom_range(0, 255)));
            else if (r < 94)
            begin
                addr = $urandom;
                if (addr >= FLASH_LOW && addr < FLASH_END)
                    addr = addr ^ 32'hF000_0000;
                send_request(ACT_WRITE, addr, 8'($urandom_range(0, 255)));
            end
            else if (r < 97)
                send_request(ACT_WRITE, PROT_LOW + $urandom_range(0, 16'h3FFF),
                             8'($urandom_range(0, 255)));
            else
                send_request(ACT_UNUSED, $urandom, 8'($urandom_range(0, 255)));
        end
        send_quiet = 1'b0;
        recv_quiet = 1'b0;
    endtask

    // The receiver holds off for a long stretch while requests keep coming.
    task automatic test_output_stall();
        logic [31:0] base;
        idle_input();
        wait_drained();
        send_request(ACT_UNLOCK, 32'h0, 8'h0);
        send_quiet = 1'b1;
        hold_requests++;
        for (int i = 0; i < 40; i++)
        begin
            if (i % 5 == 0)
                base = pick_word_addr();
            send_request(ACT_WRITE, base + $urandom_range(0, 7), 8'($urandom_range(0, 255)));
        end
        send_request(ACT_LOCK, 32'h0, 8'h0);
        send_quiet = 1'b0;
    endtask

    // Test sequence and final verdict.
    initial
    begin
        unlocked     = 1'b0;
        pend_valid   = 1'b0;
        pend_base    = '0;
        pend_word    = ALL_ONES;
        pend_mask    = '0;
        erased_pages = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random();
        test_output_stall();

        idle_input();
        wait_drained();

        $display("Checked %0d result words from %0d requests (%0d programs, %0d erases).",
                 words_checked, requests_sent, programs_expected, erases_expected);
        $display("Runs included random gaps on both sides and a %0d-cycle output stall.",
                 LONG_HOLD);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
